### src/i2cbm_pkg.sv
package i2cbm_pkg;

  // Command opcodes
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;
  localparam logic [2:0] OP_ADDR_WR   = 3'd6;
  localparam logic [2:0] OP_ADDR_RD   = 3'd7;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDR  = 1'b0;
  localparam logic CFG_HALF_PERIOD = 1'b1;

  localparam int          CFG_DATA_W         = 16;
  localparam logic [6:0]  SLAVE_ADDR_RESET   = 7'h30;
  localparam logic [15:0] HALF_PERIOD_RESET  = 16'd100;

  // Request queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] cmd_data;
    logic       sda_in;
  } in_req_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_status;
  } out_res_t;

  // Queue head as seen by the sequencer
  typedef struct packed {
    logic    valid;
    in_req_t req;
  } queue_head_t;

  // SDA drive level at the start of a bit's low phase
  function automatic logic bit_low_sda(input logic [2:0] cmd, input logic [3:0] bit_idx,
                                       input logic [7:0] sh);
    logic last;
    last = (bit_idx >= 4'd8);
    if (cmd inside {OP_READ_ACK, OP_READ_NACK}) begin
      return last ? (cmd == OP_READ_ACK) : 1'b0;
    end else begin
      return last ? 1'b0 : ~sh[7];
    end
  endfunction

endpackage

### src/i2cbm_queue.sv
module i2cbm_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  i2cbm_pkg::in_req_t        in_req,
  output i2cbm_pkg::queue_head_t    head,
  input  logic                      pop
);
  import i2cbm_pkg::*;

  in_req_t                 slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]  count_r;
  logic                    push, do_pop;

  // Full queue holds off the producer
  assign in_stall = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.req   = slot_r[rd_ptr_r];

  // Request storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_req;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(do_pop);
    end
  end

endmodule

### src/i2cbm_seq.sv
module i2cbm_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  i2cbm_pkg::queue_head_t       head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output i2cbm_pkg::out_res_t          out_res
);
  import i2cbm_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_HI = 4'd1;
  localparam logic [3:0] PH_START_LO = 4'd2;
  localparam logic [3:0] PH_STOP_LO  = 4'd3;
  localparam logic [3:0] PH_STOP_HI  = 4'd4;
  localparam logic [3:0] PH_BIT_LOW  = 4'd5;
  localparam logic [3:0] PH_BIT_HIGH = 4'd6;

  logic [6:0]  slave_addr_r;
  logic [15:0] half_period_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        ack_r, ack_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        done;

  logic        out_valid_r;
  out_res_t    out_res_r, out_res_nxt;

  logic [15:0] limit;
  logic [16:0] cnt_inc;
  logic        over;
  logic [15:0] cnt_after;
  logic [7:0]  sh;
  logic [7:0]  first_byte;

  // Take the next request whenever the output register is free
  assign pop       = head.valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r  <= SLAVE_ADDR_RESET;
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SLAVE_ADDR:  slave_addr_r  <= cfg_wdata[6:0];
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Half-period timer
  assign limit     = (half_period_r == '0) ? 16'd1 : half_period_r;
  assign cnt_inc   = {1'b0, cnt_r} + 17'd1;
  assign over      = (cnt_inc >= {1'b0, limit});
  assign cnt_after = over ? 16'd0 : cnt_inc[15:0];

  // Byte loaded by a byte command
  always_comb begin
    case (head.req.opcode)
      OP_WRITE:   first_byte = head.req.cmd_data;
      OP_ADDR_WR: first_byte = {slave_addr_r, 1'b0};
      OP_ADDR_RD: first_byte = {slave_addr_r, 1'b1};
      default:    first_byte = 8'h00;
    endcase
  end

  // One bus tick per request
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    ack_nxt   = ack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    hold_nxt  = hold_r;
    done      = 1'b0;
    sh        = shift_r;
    case (phase_r)
      PH_IDLE: begin
        if (head.req.opcode != OP_NONE) begin
          cmd_nxt = head.req.opcode;
          cnt_nxt = '0;
          bit_nxt = '0;
          case (head.req.opcode)
            OP_START: begin
              phase_nxt = PH_START_HI;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
            end
            OP_STOP: begin
              phase_nxt = PH_STOP_LO;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
            default: begin
              shift_nxt = first_byte;
              phase_nxt = PH_BIT_LOW;
              scl_nxt   = 1'b1;
              sda_nxt   = bit_low_sda(head.req.opcode, 4'd0, first_byte);
            end
          endcase
        end
      end
      PH_START_HI: begin
        cnt_nxt = cnt_after;
        if (over) begin
          phase_nxt = PH_START_LO;
          sda_nxt   = 1'b1;
        end
      end
      PH_START_LO: begin
        cnt_nxt = cnt_after;
        if (over) begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_STOP_LO: begin
        cnt_nxt = cnt_after;
        if (over) begin
          phase_nxt = PH_STOP_HI;
          scl_nxt   = 1'b0;
        end
      end
      PH_STOP_HI: begin
        cnt_nxt = cnt_after;
        if (over) begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_BIT_LOW: begin
        cnt_nxt = cnt_after;
        if (over) begin
          phase_nxt = PH_BIT_HIGH;
          scl_nxt   = 1'b0;
        end
      end
      PH_BIT_HIGH: begin
        cnt_nxt = cnt_after;
        if (over) begin
          // Sample on the end of the SCL-high phase
          if (cmd_r inside {OP_READ_ACK, OP_READ_NACK}) begin
            if (bit_r < 4'd8) begin
              sh = {shift_r[6:0], head.req.sda_in};
              if (bit_r == 4'd7) begin
                hold_nxt = sh;
              end
            end
          end else begin
            if (bit_r < 4'd8) begin
              sh = {shift_r[6:0], 1'b0};
            end else begin
              ack_nxt = head.req.sda_in;
            end
          end
          shift_nxt = sh;
          scl_nxt   = 1'b1;
          if (bit_r >= 4'd8) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 4'd1;
            phase_nxt = PH_BIT_LOW;
            sda_nxt   = bit_low_sda(cmd_r, bit_r + 4'd1, sh);
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase

    out_res_nxt.scl_drive_low = scl_nxt;
    out_res_nxt.sda_drive_low = sda_nxt;
    out_res_nxt.busy_res      = (phase_nxt != PH_IDLE);
    out_res_nxt.done_res      = done;
    out_res_nxt.read_data     = hold_nxt;
    out_res_nxt.ack_status    = ack_nxt;
  end

  // Sequencer state advances once per popped request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= '0;
      bit_r   <= '0;
      cnt_r   <= '0;
      shift_r <= '0;
      ack_r   <= 1'b0;
      scl_r   <= 1'b0;
      sda_r   <= 1'b0;
      hold_r  <= '0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      bit_r   <= bit_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      ack_r   <= ack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= out_res_nxt;
    end
  end

endmodule

### src/i2c_byte_master.sv
// Channel | Direction | Handshake           | Payload
// in_     | in        | in_valid / in_stall | in_req  (opcode, cmd_data, sda_in)
// out_    | out       | out_valid/out_stall | out_res (lines, busy, done, data, ack)
// cfg_    | in        | cfg_wr_en           | cfg_index, cfg_wdata
//
// One request per cycle while out_stall is low: each request is one bus tick of the sequencer.
// The acceptance edge writes the queue; the sequencer's output register is loaded
// from the queue head once it is free, and the two-entry queue absorbs output stalls.
// Reset (rst_n low, synchronous) empties the queue, drops the output, idles the
// bus and restores slave address 0x30 and 100 ticks per half period.
// in_stall rises only when the queue is full.
module i2c_byte_master (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  i2cbm_pkg::in_req_t                in_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output i2cbm_pkg::out_res_t               out_res,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import i2cbm_pkg::*;

  queue_head_t head;
  logic        pop;

  // Front: request queue
  i2cbm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .head     (head),
    .pop      (pop)
  );

  // Back: bus sequencer
  i2cbm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

### src/i2cbm_checker.sv
module i2cbm_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_stall,
  input  i2cbm_pkg::out_res_t out_res
);
  import i2cbm_pkg::*;

  // A completing command leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_res.done_res && out_res.busy_res))
    else $error("done and busy together");

  // Completion with SCL released is only the end of a stop: SDA released too
  a_stop_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.done_res && !out_res.scl_drive_low) |-> !out_res.sda_drive_low)
    else $error("SDA held low after stop");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

endmodule

bind i2c_byte_master i2cbm_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);
